FILE: hdl/cssa_pkg.sv
// Package for the 3D cut scan significance block: item and result types,
// sequencer states, register indexes and fixed-point constants.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package cssa_pkg;

   // Default grid limits along the three cut axes.
   localparam int DEF_MAX_X = 32;
   localparam int DEF_MAX_Y = 32;
   localparam int DEF_MAX_Z = 32;

   // Register reset values.
   localparam logic [5:0]  RST_DIM_X   = 6'd20;
   localparam logic [5:0]  RST_DIM_Y   = 6'd30;
   localparam logic [5:0]  RST_DIM_Z   = 6'd30;
   localparam logic [31:0] RST_MIN_BKG = 32'd32768;

   // ln(2) in Q0.32.
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DIM_X   = 2'd0;
   localparam logic [1:0] CSR_DIM_Y   = 2'd1;
   localparam logic [1:0] CSR_DIM_Z   = 2'd2;
   localparam logic [1:0] CSR_MIN_BKG = 2'd3;

   typedef struct packed {
      logic [31:0] sig_weight;
      logic [31:0] bkg_weight;
      logic        last_bin;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic        found;
      logic [4:0]  best_x;
      logic [4:0]  best_y;
      logic [4:0]  best_z;
      logic [31:0] best_value;
      logic [47:0] sig_total;
      logic [47:0] bkg_total;
      logic        last_result;
   } rsp_type;

   // Best-so-far record for one figure of merit.
   typedef struct packed {
      logic        found;
      logic [4:0]  x;
      logic [4:0]  y;
      logic [4:0]  z;
      logic [31:0] value;
      logic [47:0] s;
      logic [47:0] b;
   } rec_type;

   // Axis of the current suffix-sum pass.
   typedef enum logic [1:0] {
      PASS_Z,
      PASS_Y,
      PASS_X
   } pass_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SUM_ADDR,
      S_SUM_PART,
      S_SUM_SELF,
      S_SCAN_RD,
      S_SCAN_GET,
      S_RAT_CHK,
      S_RAT_DIV,
      S_LOG_NORM,
      S_LOG_SQ,
      S_LN_FP,
      S_LN_IP,
      S_PROD,
      S_SUB,
      S_SQRT,
      S_OFFER,
      S_OUT0,
      S_OUT1
   } st_type;

endpackage

`default_nettype wire

FILE: hdl/cut_scan_significance_argmax_core.sv
// Top level of the 3D cut scan: bin memories, suffix-sum passes and the
// per-cell significance and ratio sequencer. Depends on cssa_pkg.
`default_nettype none

// Bins are taken one item per cycle into two on-chip grids in raster order
// (x outermost, z innermost); bins beyond the configured grid are dropped.
// The item flagged last_bin starts the processing, and req_stall stays high
// until both results have been taken. The suffix sums take three passes over
// the grid, a summed cell via the address, partial and self states, a skipped
// edge cell via the address state alone, all through the single memory read
// port. The scan reads every cell and, for one whose background passes the
// threshold, runs a 32-step divider, two 6-step normalizations and two
// 32-step squaring loops for the logarithms on one shared 32x32 multiplier,
// four partial products for the wide product and a 32-step square root. Two
// results follow, significance first, ratio second. No clearing pass is run.
module cut_scan_significance_argmax_core
   import cssa_pkg::*;
#(
   parameter int MAX_X = DEF_MAX_X,
   parameter int MAX_Y = DEF_MAX_Y,
   parameter int MAX_Z = DEF_MAX_Z
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = $clog2(CELLS + 1);
   localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

   function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] t;
      t = {1'b0, a} + {1'b0, b};
      sat48 = t[48] ? '1 : t[47:0];
   endfunction

   // Bin memories.
   logic [47:0] sig_mem [CELLS];
   logic [47:0] bkg_mem [CELLS];
   logic [47:0] sig_rd_ff, bkg_rd_ff;
   logic          mem_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [47:0]   wr_sig, wr_bkg;

   // Control and datapath registers.
   st_type        state_ff, state_in;
   pass_type      pass_ff, pass_in;
   logic [CW-1:0] load_pos_ff, load_pos_in;
   logic [5:0]    dim_x_ff, dim_x_in, dim_y_ff, dim_y_in, dim_z_ff, dim_z_in;
   logic [31:0]   min_bkg_ff, min_bkg_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [XW-1:0] cx_ff, cx_in;
   logic [YW-1:0] cy_ff, cy_in;
   logic [ZW-1:0] cz_ff, cz_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [47:0]   part_sig_ff, part_sig_in, part_bkg_ff, part_bkg_in;
   logic [47:0]   s_ff, s_in, b_ff, b_in;
   logic [48:0]   n_ff, n_in;
   logic [47:0]   rem_ff, rem_in;
   logic [31:0]   dvd_ff, dvd_in, quo_ff, quo_in;
   logic [63:0]   w_ff, w_in;
   logic [5:0]    e_ff, e_in;
   logic [31:0]   m_ff, m_in, frac_ff, frac_in;
   logic          log_sel_ff, log_sel_in;
   logic [37:0]   ln_n_ff, ln_n_in, ln_d_ff, ln_d_in;
   logic [31:0]   lfp_ff, lfp_in;
   logic [39:0]   lval_ff, lval_in;
   logic [89:0]   acc_ff, acc_in;
   logic [63:0]   rad_ff, rad_in, res_ff, res_in, one_ff, one_in;
   logic [31:0]   zval_ff, zval_in;
   rec_type       sig_rec_ff, sig_rec_in, rat_rec_ff, rat_rec_in;

   // Derived geometry.
   logic [6:0]    dxc, dyc, dzc;
   logic [XW-1:0] dxm1;
   logic [YW-1:0] dym1;
   logic [ZW-1:0] dzm1;
   logic [CW-1:0] cells, plane, stride;

   // Conditions shared by the sequencer and the datapath.
   logic req_acc, sum_skip, sum_wrap, scan_last, eligible, rat_sat;
   logic ln_nonpos, sub_zero, sub_sat;
   logic [89:0] sub_ref, sub_d;

   // Shared multiplier.
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   // Step helpers.
   logic [48:0] div_t;
   logic        div_ge;
   logic        norm_zero;
   logic [63:0] w_sh;
   logic [5:0]  nsh;
   logic [32:0] sq_t;
   logic [31:0] frac_nx;
   logic [37:0] ln_diff;
   logic [63:0] sq_sum;
   logic        sq_ge;
   logic [6:0]  pp_sh;
   logic        do_sum_adv, do_scan_adv;
   rec_type     rec_out;

   // Grid geometry from the registers, each axis clamped to its limit.
   always_comb begin
      dxc = (dim_x_ff == 6'd0) ? 7'd1 :
            ((7'(dim_x_ff) > 7'(MAX_X)) ? 7'(MAX_X) : 7'(dim_x_ff));
      dyc = (dim_y_ff == 6'd0) ? 7'd1 :
            ((7'(dim_y_ff) > 7'(MAX_Y)) ? 7'(MAX_Y) : 7'(dim_y_ff));
      dzc = (dim_z_ff == 6'd0) ? 7'd1 :
            ((7'(dim_z_ff) > 7'(MAX_Z)) ? 7'(MAX_Z) : 7'(dim_z_ff));
      dxm1  = XW'(dxc - 7'd1);
      dym1  = YW'(dyc - 7'd1);
      dzm1  = ZW'(dzc - 7'd1);
      cells = CW'(21'(dxc) * 21'(dyc) * 21'(dzc));
      plane = CW'(14'(dyc) * 14'(dzc));
   end

   // Conditions.
   always_comb begin
      req_acc = req_valid && !req_stall;
      case (pass_ff)
         PASS_Z: begin
            sum_skip = (cz_ff == dzm1);
            stride   = CW'(1);
         end
         PASS_Y: begin
            sum_skip = (cy_ff == dym1);
            stride   = CW'(dzc);
         end
         PASS_X: begin
            sum_skip = (cx_ff == dxm1);
            stride   = plane;
         end
         default: begin
            sum_skip = 1'b1;
            stride   = CW'(1);
         end
      endcase
      sum_wrap  = (idx_ff == '0);
      scan_last = ((CW'(idx_ff) + CW'(1)) == cells);
      eligible  = (bkg_rd_ff > {16'd0, min_bkg_ff});
      rat_sat   = ({16'd0, s_ff} >= {b_ff, 16'd0});
      ln_diff   = ln_n_ff - ln_d_ff;
      ln_nonpos = (ln_n_ff <= ln_d_ff);
      sub_ref   = {10'd0, s_ff, 32'd0};
      sub_zero  = (acc_ff <= sub_ref);
      sub_d     = acc_ff - sub_ref;
      sub_sat   = |sub_d[89:79];
   end

   // Multiplier operand selection and the product.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      pp_sh = 7'd0;
      case (state_ff)
         S_LOG_SQ: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         S_LN_FP: begin
            mul_a = ln_diff[31:0];
            mul_b = LN2_Q32;
         end
         S_LN_IP: begin
            mul_a = 32'(ln_diff[37:32]);
            mul_b = LN2_Q32;
         end
         S_PROD: begin
            case (cnt_ff)
               5'd0: begin
                  mul_a = n_ff[31:0];
                  mul_b = lval_ff[31:0];
                  pp_sh = 7'd0;
               end
               5'd1: begin
                  mul_a = n_ff[31:0];
                  mul_b = 32'(lval_ff[39:32]);
                  pp_sh = 7'd32;
               end
               5'd2: begin
                  mul_a = 32'(n_ff[48:32]);
                  mul_b = lval_ff[31:0];
                  pp_sh = 7'd32;
               end
               default: begin
                  mul_a = 32'(n_ff[48:32]);
                  mul_b = 32'(lval_ff[39:32]);
                  pp_sh = 7'd64;
               end
            endcase
         end
         default: begin
            mul_a = '0;
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   // Step logic of the divider, normalizer, squaring loop and square root.
   always_comb begin
      div_t  = {rem_ff, dvd_ff[31]};
      div_ge = (div_t >= {1'b0, b_ff});
      case (cnt_ff)
         5'd0: begin
            norm_zero = (w_ff[63:32] == '0);
            w_sh      = w_ff << 32;
            nsh       = 6'd32;
         end
         5'd1: begin
            norm_zero = (w_ff[63:48] == '0);
            w_sh      = w_ff << 16;
            nsh       = 6'd16;
         end
         5'd2: begin
            norm_zero = (w_ff[63:56] == '0);
            w_sh      = w_ff << 8;
            nsh       = 6'd8;
         end
         5'd3: begin
            norm_zero = (w_ff[63:60] == '0);
            w_sh      = w_ff << 4;
            nsh       = 6'd4;
         end
         5'd4: begin
            norm_zero = (w_ff[63:62] == '0);
            w_sh      = w_ff << 2;
            nsh       = 6'd2;
         end
         default: begin
            norm_zero = !w_ff[63];
            w_sh      = w_ff << 1;
            nsh       = 6'd1;
         end
      endcase
      sq_t    = mul_p[63:31];
      frac_nx = {frac_ff[30:0], sq_t[32]};
      sq_sum  = res_ff + one_ff;
      sq_ge   = (rad_ff >= sq_sum);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_data.last_bin) state_in = S_SUM_ADDR;
         end
         S_SUM_ADDR: begin
            if (sum_skip) begin
               state_in = (sum_wrap && pass_ff == PASS_X) ? S_SCAN_RD : S_SUM_ADDR;
            end else begin
               state_in = S_SUM_PART;
            end
         end
         S_SUM_PART: state_in = S_SUM_SELF;
         S_SUM_SELF: begin
            state_in = (sum_wrap && pass_ff == PASS_X) ? S_SCAN_RD : S_SUM_ADDR;
         end
         S_SCAN_RD: state_in = S_SCAN_GET;
         S_SCAN_GET: begin
            if (eligible) state_in = S_RAT_CHK;
            else state_in = scan_last ? S_OUT0 : S_SCAN_RD;
         end
         S_RAT_CHK: state_in = rat_sat ? S_LOG_NORM : S_RAT_DIV;
         S_RAT_DIV: begin
            if (cnt_ff == 5'd31) state_in = S_LOG_NORM;
         end
         S_LOG_NORM: begin
            if (cnt_ff == 5'd5) state_in = S_LOG_SQ;
         end
         S_LOG_SQ: begin
            if (cnt_ff == 5'd31) state_in = log_sel_ff ? S_LN_FP : S_LOG_NORM;
         end
         S_LN_FP: state_in = ln_nonpos ? S_OFFER : S_LN_IP;
         S_LN_IP: state_in = S_PROD;
         S_PROD: begin
            if (cnt_ff == 5'd3) state_in = S_SUB;
         end
         S_SUB: state_in = (sub_zero || sub_sat) ? S_OFFER : S_SQRT;
         S_SQRT: begin
            if (cnt_ff == 5'd31) state_in = S_OFFER;
         end
         S_OFFER: state_in = scan_last ? S_OUT0 : S_SCAN_RD;
         S_OUT0: begin
            if (!rsp_stall) state_in = S_OUT1;
         end
         S_OUT1: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Handshake and memory port outputs.
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_OUT0) || (state_ff == S_OUT1);
      csr_ready = 1'b1;
      mem_we    = 1'b0;
      wr_addr   = idx_ff;
      wr_sig    = sat48(sig_rd_ff, part_sig_ff);
      wr_bkg    = sat48(bkg_rd_ff, part_bkg_ff);
      rd_addr   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            mem_we  = req_acc && (load_pos_ff < cells);
            wr_addr = AW'(load_pos_ff);
            wr_sig  = 48'(req_data.sig_weight);
            wr_bkg  = 48'(req_data.bkg_weight);
         end
         S_SUM_ADDR: rd_addr = AW'(CW'(idx_ff) + stride);
         S_SUM_SELF: mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   // Result payload.
   always_comb begin
      rec_out              = (state_ff == S_OUT1) ? rat_rec_ff : sig_rec_ff;
      rsp_data.result_kind = (state_ff == S_OUT1);
      rsp_data.found       = rec_out.found;
      rsp_data.best_x      = rec_out.x;
      rsp_data.best_y      = rec_out.y;
      rsp_data.best_z      = rec_out.z;
      rsp_data.best_value  = rec_out.value;
      rsp_data.sig_total   = rec_out.s;
      rsp_data.bkg_total   = rec_out.b;
      rsp_data.last_result = (state_ff == S_OUT1);
   end

   // Datapath next values.
   always_comb begin
      pass_in     = pass_ff;
      load_pos_in = load_pos_ff;
      dim_x_in    = dim_x_ff;
      dim_y_in    = dim_y_ff;
      dim_z_in    = dim_z_ff;
      min_bkg_in  = min_bkg_ff;
      idx_in      = idx_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      part_sig_in = part_sig_ff;
      part_bkg_in = part_bkg_ff;
      s_in        = s_ff;
      b_in        = b_ff;
      n_in        = n_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      w_in        = w_ff;
      e_in        = e_ff;
      m_in        = m_ff;
      frac_in     = frac_ff;
      log_sel_in  = log_sel_ff;
      ln_n_in     = ln_n_ff;
      ln_d_in     = ln_d_ff;
      lfp_in      = lfp_ff;
      lval_in     = lval_ff;
      acc_in      = acc_ff;
      rad_in      = rad_ff;
      res_in      = res_ff;
      one_in      = one_ff;
      zval_in     = zval_ff;
      sig_rec_in  = sig_rec_ff;
      rat_rec_in  = rat_rec_ff;
      do_sum_adv  = 1'b0;
      do_scan_adv = 1'b0;

      // Register writes.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIM_X:   dim_x_in   = csr_wdata[5:0];
            CSR_DIM_Y:   dim_y_in   = csr_wdata[5:0];
            CSR_DIM_Z:   dim_z_in   = csr_wdata[5:0];
            CSR_MIN_BKG: min_bkg_in = csr_wdata;
            default:     min_bkg_in = min_bkg_ff;
         endcase
      end

      case (state_ff)
         // Load one bin per item; the last item starts the z pass at the end.
         S_IDLE: begin
            if (req_acc) begin
               if (load_pos_ff < cells) load_pos_in = load_pos_ff + CW'(1);
               if (req_data.last_bin) begin
                  pass_in = PASS_Z;
                  idx_in  = AW'(cells - CW'(1));
                  cx_in   = dxm1;
                  cy_in   = dym1;
                  cz_in   = dzm1;
               end
            end
         end
         S_SUM_ADDR: do_sum_adv = sum_skip;
         S_SUM_PART: begin
            part_sig_in = sig_rd_ff;
            part_bkg_in = bkg_rd_ff;
         end
         S_SUM_SELF: do_sum_adv = 1'b1;
         // Take the cell totals.
         S_SCAN_GET: begin
            s_in        = sig_rd_ff;
            b_in        = bkg_rd_ff;
            do_scan_adv = !eligible;
         end
         // Ratio saturation check, or set up the restoring divider.
         S_RAT_CHK: begin
            n_in       = {1'b0, s_ff} + {1'b0, b_ff};
            log_sel_in = 1'b0;
            if (rat_sat) begin
               quo_in = '1;
               w_in   = 64'({1'b0, s_ff} + {1'b0, b_ff});
               e_in   = 6'd63;
            end else begin
               rem_in = {16'd0, s_ff[47:16]};
               dvd_in = {s_ff[15:0], 16'd0};
               quo_in = '0;
            end
         end
         // One quotient bit per cycle.
         S_RAT_DIV: begin
            rem_in = div_ge ? 48'(div_t - {1'b0, b_ff}) : div_t[47:0];
            dvd_in = dvd_ff << 1;
            quo_in = {quo_ff[30:0], div_ge};
            if (cnt_ff == 5'd31) begin
               w_in = 64'(n_ff);
               e_in = 6'd63;
            end
         end
         // Leading-one search in halving steps.
         S_LOG_NORM: begin
            if (norm_zero) begin
               w_in = w_sh;
               e_in = e_ff - nsh;
            end
            if (cnt_ff == 5'd5) begin
               m_in    = norm_zero ? w_sh[63:32] : w_ff[63:32];
               frac_in = '0;
            end
         end
         // One fraction bit of the logarithm per squaring.
         S_LOG_SQ: begin
            m_in    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            frac_in = frac_nx;
            if (cnt_ff == 5'd31) begin
               if (log_sel_ff) begin
                  ln_d_in = {e_ff, frac_nx};
               end else begin
                  ln_n_in    = {e_ff, frac_nx};
                  log_sel_in = 1'b1;
                  w_in       = 64'(b_ff);
                  e_in       = 6'd63;
               end
            end
         end
         S_LN_FP: begin
            lfp_in = mul_p[63:32];
            if (ln_nonpos) zval_in = '0;
         end
         S_LN_IP: begin
            lval_in = 40'(mul_p) + 40'(lfp_ff);
            acc_in  = '0;
         end
         // Wide product from four partial products.
         S_PROD: acc_in = acc_ff + (90'(mul_p) << pp_sh);
         S_SUB: begin
            if (sub_zero) begin
               zval_in = '0;
            end else if (sub_sat) begin
               zval_in = '1;
            end else begin
               rad_in = sub_d[78:15];
               res_in = '0;
               one_in = 64'(1) << 62;
            end
         end
         // Digit-by-digit square root.
         S_SQRT: begin
            rad_in = sq_ge ? (rad_ff - sq_sum) : rad_ff;
            res_in = sq_ge ? ((res_ff >> 1) + one_ff) : (res_ff >> 1);
            one_in = one_ff >> 2;
            if (cnt_ff == 5'd31) begin
               zval_in = sq_ge ? 32'((res_ff >> 1) + one_ff) : 32'(res_ff >> 1);
            end
         end
         // Keep the first strict maximum of each figure.
         S_OFFER: begin
            if (!sig_rec_ff.found || zval_ff > sig_rec_ff.value) begin
               sig_rec_in.found = 1'b1;
               sig_rec_in.value = zval_ff;
               sig_rec_in.x     = 5'(cx_ff);
               sig_rec_in.y     = 5'(cy_ff);
               sig_rec_in.z     = 5'(cz_ff);
               sig_rec_in.s     = s_ff;
               sig_rec_in.b     = b_ff;
            end
            if (!rat_rec_ff.found || quo_ff > rat_rec_ff.value) begin
               rat_rec_in.found = 1'b1;
               rat_rec_in.value = quo_ff;
               rat_rec_in.x     = 5'(cx_ff);
               rat_rec_in.y     = 5'(cy_ff);
               rat_rec_in.z     = 5'(cz_ff);
               rat_rec_in.s     = s_ff;
               rat_rec_in.b     = b_ff;
            end
            do_scan_adv = 1'b1;
         end
         S_OUT1: begin
            if (!rsp_stall) load_pos_in = '0;
         end
         default: begin
            do_scan_adv = 1'b0;
         end
      endcase

      // Suffix-sum walk: descending raster order, three passes.
      if (do_sum_adv) begin
         if (sum_wrap) begin
            if (pass_ff == PASS_X) begin
               idx_in     = '0;
               cx_in      = '0;
               cy_in      = '0;
               cz_in      = '0;
               sig_rec_in = '0;
               rat_rec_in = '0;
            end else begin
               pass_in = (pass_ff == PASS_Z) ? PASS_Y : PASS_X;
               idx_in  = AW'(cells - CW'(1));
               cx_in   = dxm1;
               cy_in   = dym1;
               cz_in   = dzm1;
            end
         end else begin
            idx_in = idx_ff - AW'(1);
            if (cz_ff == '0) begin
               cz_in = dzm1;
               if (cy_ff == '0) begin
                  cy_in = dym1;
                  cx_in = cx_ff - XW'(1);
               end else begin
                  cy_in = cy_ff - YW'(1);
               end
            end else begin
               cz_in = cz_ff - ZW'(1);
            end
         end
      end

      // Scan walk: ascending raster order.
      if (do_scan_adv && !scan_last) begin
         idx_in = idx_ff + AW'(1);
         if (cz_ff == dzm1) begin
            cz_in = '0;
            if (cy_ff == dym1) begin
               cy_in = '0;
               cx_in = cx_ff + XW'(1);
            end else begin
               cy_in = cy_ff + YW'(1);
            end
         end else begin
            cz_in = cz_ff + ZW'(1);
         end
      end

      // Step counter restarts on every state change.
      cnt_in = (state_in != state_ff) ? 5'd0 : cnt_ff + 5'd1;
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sig_mem[wr_addr] <= wr_sig;
         bkg_mem[wr_addr] <= wr_bkg;
      end
      sig_rd_ff <= sig_mem[rd_addr];
      bkg_rd_ff <= bkg_mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pass_ff     <= PASS_Z;
         load_pos_ff <= '0;
         dim_x_ff    <= RST_DIM_X;
         dim_y_ff    <= RST_DIM_Y;
         dim_z_ff    <= RST_DIM_Z;
         min_bkg_ff  <= RST_MIN_BKG;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         pass_ff     <= pass_in;
         load_pos_ff <= load_pos_in;
         dim_x_ff    <= dim_x_in;
         dim_y_ff    <= dim_y_in;
         dim_z_ff    <= dim_z_in;
         min_bkg_ff  <= min_bkg_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      part_sig_ff <= part_sig_in;
      part_bkg_ff <= part_bkg_in;
      s_ff        <= s_in;
      b_ff        <= b_in;
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      w_ff        <= w_in;
      e_ff        <= e_in;
      m_ff        <= m_in;
      frac_ff     <= frac_in;
      log_sel_ff  <= log_sel_in;
      ln_n_ff     <= ln_n_in;
      ln_d_ff     <= ln_d_in;
      lfp_ff      <= lfp_in;
      lval_ff     <= lval_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      res_ff      <= res_in;
      one_ff      <= one_in;
      zval_ff     <= zval_in;
      sig_rec_ff  <= sig_rec_in;
      rat_rec_ff  <= rat_rec_in;
   end

endmodule

`default_nettype wire
